### rtl/core/deq_pkg.sv
// Shared definitions for the double-ended queue core.
// Holds the word width, command codes and status codes; no dependencies.
package deq_pkg;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;

endpackage

### rtl/core/deq_ring_ram.sv
// Ring storage for the double-ended queue: one write port, two read ports.
// Read data is registered. Depends on deq_pkg.
module deq_ring_ram #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  deq_pkg::word_type      wr_data,
   input  logic                   rd_en_a,
   input  logic [IDX_W-1:0]       rd_addr_a,
   output deq_pkg::word_type      rd_data_a,
   input  logic                   rd_en_b,
   input  logic [IDX_W-1:0]       rd_addr_b,
   output deq_pkg::word_type      rd_data_b
);
   import deq_pkg::*;

   word_type mem [DEPTH];
   word_type rd_a_ff;
   word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/core/double_ended_queue_core.sv
// Double-ended queue core: a bounded deque of signed words in a ring memory.
// A push, a pop of an empty queue or an unused command runs through the states EXEC, READ
// and LOAD, a pop through EXEC, POP, READ and LOAD, and a search through EXEC, SEARCH,
// READ and LOAD; SEARCH compares one stored entry per cycle through ring read port A.
// One transaction is in work at a time; the next is accepted the cycle after the result
// is loaded, later if the output register waits. Synchronous reset empties the queue.
module double_ended_queue_core #(
   parameter int DEPTH = 16,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int RSP_W = ((3 * deq_pkg::DATA_W + 4 + CNT_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [2:0] command
   input  logic [deq_pkg::CMD_W-1:0]     req_tuser,
   // [31:0] value_in
   input  logic [deq_pkg::DATA_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // popped_value, found, front_value, back_value, entry_count, empty, status,
   // from the lowest bit up, then zero fill
   output logic [RSP_W-1:0]              rsp_tdata
);
   import deq_pkg::*;

   localparam int POP_LSB   = 0;
   localparam int FOUND_LSB = DATA_W;
   localparam int FRONT_LSB = DATA_W + 1;
   localparam int BACK_LSB  = 2 * DATA_W + 1;
   localparam int CNT_LSB   = 3 * DATA_W + 1;
   localparam int EMPTY_LSB = CNT_LSB + CNT_W;
   localparam int STAT_LSB  = EMPTY_LSB + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_LOAD   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   word_type            value_ff, value_in;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   word_type            popped_ff, popped_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic                rd_en_a;
   logic [IDX_W-1:0]    rd_addr_a;
   logic                rd_en_b;
   word_type            rd_data_a;
   word_type            rd_data_b;

   logic [IDX_W-1:0]    front_inc;
   logic [IDX_W-1:0]    front_dec;
   logic [IDX_W-1:0]    tail_addr;
   logic [IDX_W-1:0]    back_addr;
   logic [IDX_W-1:0]    addr_inc;
   logic                queue_empty;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] sum);
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         return IDX_W'(sum - (IDX_W + 1)'(DEPTH));
      end else begin
         return IDX_W'(sum);
      end
   endfunction

   assign queue_empty = (occ_ff == '0);
   assign front_inc = wrap_idx({1'b0, front_ff} + (IDX_W + 1)'(1));
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign tail_addr = wrap_idx({1'b0, front_ff} + (IDX_W + 1)'(occ_ff));
   assign back_addr = queue_empty ? front_ff
                    : wrap_idx({1'b0, front_ff} + (IDX_W + 1)'(occ_ff - CNT_W'(1)));
   assign addr_inc  = wrap_idx({1'b0, addr_ff} + (IDX_W + 1)'(1));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_en_a = (state_ff == S_EXEC) || (state_ff == S_SEARCH) || (state_ff == S_READ);
   assign rd_en_b = (state_ff == S_READ);

   always_comb begin
      unique case (state_ff)
         S_EXEC:   rd_addr_a = (cmd_ff == CMD_POP_BACK) ? back_addr : front_ff;
         S_SEARCH: rd_addr_a = addr_ff;
         default:  rd_addr_a = front_ff;
      endcase
   end

   deq_ring_ram #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_en_a   (rd_en_a),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_en_b   (rd_en_b),
      .rd_addr_b (back_addr),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      popped_in    = popped_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_tuser;
               value_in  = word_type'(req_tdata);
               popped_in = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff) inside
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (occ_ff == CNT_W'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     occ_in = occ_ff + CNT_W'(1);
                     if (cmd_ff == CMD_PUSH_FRONT) begin
                        wr_addr  = front_dec;
                        front_in = front_dec;
                     end
                  end
                  state_in = S_READ;
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  if (queue_empty) begin
                     popped_in = '1;
                     status_in = STATUS_EMPTY;
                     state_in  = S_READ;
                  end else begin
                     state_in = S_POP;
                  end
               end
               CMD_SEARCH: begin
                  addr_in  = front_ff;
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_SEARCH;
               end
               default: begin
                  state_in = S_READ;
               end
            endcase
         end
         S_POP: begin
            popped_in = rd_data_a;
            occ_in    = occ_ff - CNT_W'(1);
            if (cmd_ff == CMD_POP_FRONT) begin
               front_in = front_inc;
            end
            state_in = S_READ;
         end
         S_SEARCH: begin
            if (pend_ff && (rd_data_a == value_ff)) begin
               found_in = 1'b1;
               state_in = S_READ;
            end else if (cnt_ff == occ_ff) begin
               state_in = S_READ;
            end else begin
               addr_in = addr_inc;
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in                       = 1'b1;
               rsp_data_in                        = '0;
               rsp_data_in[POP_LSB +: DATA_W]     = popped_ff;
               rsp_data_in[FOUND_LSB]             = found_ff;
               rsp_data_in[FRONT_LSB +: DATA_W]   = queue_empty ? '1 : rd_data_a;
               rsp_data_in[BACK_LSB +: DATA_W]    = queue_empty ? '1 : rd_data_b;
               rsp_data_in[CNT_LSB +: CNT_W]      = occ_ff;
               rsp_data_in[EMPTY_LSB]             = queue_empty;
               rsp_data_in[STAT_LSB +: STATUS_W]  = status_ff;
               state_in                           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      addr_ff     <= addr_in;
      popped_ff   <= popped_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
